/* src/ring_buffer_deque_defines.svh */
// Assertion macros for the ring buffer deque.
`ifndef RING_BUFFER_DEQUE_DEFINES_SVH
`define RING_BUFFER_DEQUE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define RBD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ring_buffer_deque: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define RBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ring_buffer_deque: next-cycle check failed");

`endif

/* src/rbd_pkg.sv */
`timescale 1ns / 1ps
package rbd_pkg;

	localparam int DEPTH  = 16;
	localparam int WORD_W = 32;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CFG_W  = 5;
	localparam int OCC_W  = 5;
	localparam int OUT_W  = 32;

	typedef enum logic [1:0] {
		MODE_INSERT  = 2'd0,
		MODE_POP     = 2'd1,
		MODE_DEQUEUE = 2'd2,
		MODE_NOP     = 2'd3
	} mode_t;

	// Outcome of one transaction, known at accept time.
	typedef struct packed {
		logic             ok;
		logic             take;
		logic [CNT_W-1:0] occ;
		logic [CNT_W-1:0] cap;
	} step_t;

	// Memory request issued at accept time.
	typedef struct packed {
		logic             en;
		logic             we;
		logic [IDX_W-1:0] addr;
	} mem_req_t;

endpackage

/* src/rbd_ram.sv */
`timescale 1ns / 1ps
module rbd_ram #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// When enabled, write on we, otherwise read into the registered rdata.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

/* src/rbd_ctrl.sv */
`timescale 1ns / 1ps
module rbd_ctrl
	import rbd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             step,
	input  mode_t            mode,
	output step_t            res,
	output mem_req_t         req
);

	logic [CNT_W-1:0] cap_q;
	logic [IDX_W-1:0] front_q, back_q;
	logic             full_q;

	logic [CNT_W-1:0] occ, cap_eff, back_p1, front_p1;
	logic [IDX_W-1:0] back_inc, back_dec, front_inc;
	logic             can_ins, can_rem;

	// Clamp a written capacity into 1..DEPTH.
	always_comb begin
		if (cfg_data == '0) begin
			cap_eff = CNT_W'(1);
		end else if (CNT_W'(cfg_data) > CNT_W'(DEPTH) || 32'(cfg_data) > DEPTH) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = CNT_W'(cfg_data);
		end
	end

	// Derive occupancy and wrapped neighbor indices.
	always_comb begin
		if (full_q) begin
			occ = cap_q;
		end else if (back_q >= front_q) begin
			occ = CNT_W'(back_q) - CNT_W'(front_q);
		end else begin
			occ = cap_q - CNT_W'(front_q) + CNT_W'(back_q);
		end
		back_p1   = CNT_W'(back_q) + CNT_W'(1);
		front_p1  = CNT_W'(front_q) + CNT_W'(1);
		back_inc  = (back_p1 >= cap_q) ? '0 : IDX_W'(back_p1);
		front_inc = (front_p1 >= cap_q) ? '0 : IDX_W'(front_p1);
		back_dec  = (back_q == '0) ? IDX_W'(cap_q - CNT_W'(1)) : back_q - IDX_W'(1);
		can_ins   = occ < cap_q;
		can_rem   = occ != '0;
	end

	// Decide the outcome and the memory access of this transaction.
	always_comb begin
		res.ok   = 1'b0;
		res.take = 1'b0;
		res.occ  = occ;
		res.cap  = cap_q;
		req.en   = 1'b0;
		req.we   = 1'b0;
		req.addr = back_q;
		case (mode)
			MODE_INSERT: begin
				if (can_ins) begin
					res.ok  = 1'b1;
					res.occ = occ + CNT_W'(1);
					req.en  = step;
					req.we  = 1'b1;
				end
			end
			MODE_POP: begin
				req.addr = back_dec;
				if (can_rem) begin
					res.ok   = 1'b1;
					res.take = 1'b1;
					res.occ  = occ - CNT_W'(1);
					req.en   = step;
				end
			end
			MODE_DEQUEUE: begin
				req.addr = front_q;
				if (can_rem) begin
					res.ok   = 1'b1;
					res.take = 1'b1;
					res.occ  = occ - CNT_W'(1);
					req.en   = step;
				end
			end
			default: begin
			end
		endcase
	end

	// Advance the indices and full mark; a capacity write empties the buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CNT_W'(DEPTH);
			front_q <= '0;
			back_q  <= '0;
			full_q  <= 1'b0;
		end else if (cfg_we) begin
			cap_q   <= cap_eff;
			front_q <= '0;
			back_q  <= '0;
			full_q  <= 1'b0;
		end else if (step && res.ok) begin
			case (mode)
				MODE_INSERT: begin
					back_q <= back_inc;
					full_q <= (back_inc == front_q);
				end
				MODE_POP: begin
					back_q <= back_dec;
					full_q <= 1'b0;
				end
				MODE_DEQUEUE: begin
					front_q <= front_inc;
					full_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* src/ring_buffer_deque.sv */
`timescale 1ns / 1ps
// Ring buffer deque: a circular store of signed 32-bit words, a queue at its
// front and a stack at its back.
// Input channel s_*: s_tuser[1:0] is the mode (0 insert, 1 pop, 2 dequeue,
// 3 no operation), s_tdata[31:0] the word to insert.
// Output channel m_*: one result per input transaction. m_tuser[0] is ok,
// m_tdata[31:0] the removed word (0 unless a removal succeeded),
// m_tdata[36:32] the occupancy after the step.
// cfg_we/cfg_data write the capacity (0 reads as 1, above 16 as 16) and
// empty the buffer; write only while no transaction is in flight.
// A result passes the synchronous entry memory read and then the output
// register; a receiver stall can hold it between the two.
// Throughput: one transaction per cycle unless the receiver stalls; the
// pointers move at accept time; each transaction uses the memory port at most once.
// Reset empties the buffer and sets the capacity to 16; stored words are
// not cleared. When the receiver stalls, the output register and the read
// stage hold, and s_tready drops once both are full.
module ring_buffer_deque
	import rbd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,  // value_in[31:0]
	input  logic [1:0]       s_tuser,  // mode[1:0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [39:0]      m_tdata,  // value_out[31:0], occupancy[36:32], zero pad
	output logic [0:0]       m_tuser   // ok[0]
);

	step_t            res;
	mem_req_t         req;
	logic [WORD_W-1:0] rdata;

	logic             accept, advance;
	logic             valid_s1, ok_s1, take_s1;
	logic [CNT_W-1:0] occ_s1;
	logic             m_tvalid_q, ok_q;
	logic [OUT_W-1:0] value_q;
	logic [OCC_W-1:0] occ_q;

	assign accept   = s_tvalid && s_tready;
	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	rbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.step     (accept),
		.mode     (mode_t'(s_tuser)),
		.res      (res),
		.req      (req)
	);

	rbd_ram #(
		.DEPTH  (DEPTH),
		.WIDTH  (WORD_W),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.en    (req.en),
		.we    (req.we),
		.addr  (req.addr),
		.wdata (WORD_W'(s_tdata)),
		.rdata (rdata)
	);

	// Track the transaction waiting on the memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the outcome alongside the read.
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1   <= res.ok;
			take_s1 <= res.take;
			occ_s1  <= res.occ;
		end
	end

	// Hold the result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ok_q    <= ok_s1;
			value_q <= take_s1 ? OUT_W'(rdata) : '0;
			occ_q   <= OCC_W'(occ_s1);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, occ_q, value_q};
	assign m_tuser  = ok_q;

	`include "ring_buffer_deque_defines.svh"

	`RBD_ASSERT_SAME(a_occ_in_range, clk, arst_n, advance, occ_s1 <= res.cap)
	`RBD_ASSERT_NEXT(a_nop_rejected, clk, arst_n, accept && s_tuser == MODE_NOP, valid_s1 && !ok_s1)
	`RBD_ASSERT_SAME(a_stall_cause, clk, arst_n, !s_tready, valid_s1 && m_tvalid_q && !m_tready)

endmodule
